[sv/pht_pkg.sv]
// ----------------------------------------------------------------------------
// pht_pkg
// shared types and constants for the priority handler table
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_REGISTERED = 2'd0,
    ST_FULL       = 2'd1,
    ST_MATCH      = 2'd2,
    ST_NO_MATCH   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // one table entry
  typedef struct packed {
    logic [15:0] prio;
    logic [7:0]  evt;
    logic        wild;
    logic [7:0]  hid;
  } pht_entry_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    logic       valid;
    logic       gt;
    pht_entry_t ent;
  } pht_link_t;

  // dispatch scan data, handed from a cell to its left neighbor
  typedef struct packed {
    logic       hit;
    logic [7:0] hid;
  } pht_scan_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic       ins;
    logic       load;
    logic       shift;
    pht_entry_t ent;
  } pht_cmd_t;

endpackage

[sv/pht_cell.sv]
// ----------------------------------------------------------------------------
// pht_cell
// one slot of the sorted table: holds an entry and its dispatch scan bit
// ----------------------------------------------------------------------------
module pht_cell
  import pht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pht_cmd_t  cmd_i,
  input  pht_link_t left_i,
  output pht_link_t right_o,
  input  pht_scan_t scan_right_i,
  output pht_scan_t scan_o
);

  logic       valid_q, valid_d;
  pht_entry_t ent_q, ent_d;
  logic       hit_q, hit_d;
  logic [7:0] sid_q, sid_d;
  logic       gt;
  logic       ins_here;

  // strict compare keeps arrival order among equal priorities
  assign gt       = valid_q && ($signed(ent_q.prio) > $signed(cmd_i.ent.prio));
  assign ins_here = !left_i.gt && (gt || !valid_q) && left_i.valid;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    hit_d   = hit_q;
    sid_d   = sid_q;
    if (cmd_i.ins) begin
      if (left_i.gt) begin
        valid_d = 1'b1;
        ent_d   = left_i.ent;
      end else if (ins_here) begin
        valid_d = 1'b1;
        ent_d   = cmd_i.ent;
      end
    end
    if (cmd_i.load) begin
      hit_d = valid_q && (ent_q.wild || (ent_q.evt == cmd_i.ent.evt));
      sid_d = ent_q.hid;
    end else if (cmd_i.shift) begin
      hit_d = scan_right_i.hit;
      sid_d = scan_right_i.hid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    sid_q <= sid_d;
  end

  assign right_o.valid = valid_q;
  assign right_o.gt    = gt;
  assign right_o.ent   = ent_q;
  assign scan_o.hit    = hit_q;
  assign scan_o.hid    = sid_q;

endmodule

[sv/priority_handler_table_top.sv]
// ----------------------------------------------------------------------------
// priority_handler_table_top
// sorted table of interrupt handler entries with event dispatch
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells kept sorted by signed priority,
// lower first, equal priorities in arrival order. For a register request,
// every cell compares its priority with the new one at once and either
// keeps its entry, takes its left neighbor's, or takes the new entry; one
// result follows (registered, or full and dropped). A dispatch request
// loads a match bit into every cell, then the row of match bits shifts
// toward cell 0 one step a cycle while the result side does not stall, and
// a result leaves whenever cell 0 holds a match; the scan stops after the
// last match. A dispatch with no match gives one no-match result. A new
// request is taken only once the previous one is finished and its last
// result has left.
// ----------------------------------------------------------------------------
module priority_handler_table_top
  import pht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] priority_req_i,
  input  logic [7:0]  event_code_i,
  input  logic        any_event_i,
  input  logic [7:0]  handler_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  match_id_o,
  output logic        last_o
);

  pht_link_t                  link [TABLE_DEPTH+1];
  pht_scan_t                  scan [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]     hits;
  pht_cmd_t                   cmd;
  state_e                     state_q, state_d;
  logic                       out_valid_q, out_valid_d;
  status_e                    status_q, status_d;
  logic [7:0]                 id_q, id_d;
  logic                       last_q, last_d;
  logic                       in_take;
  logic                       out_free;
  logic                       full;
  logic                       rest;

  assign link[0]     = '{valid: 1'b1, gt: 1'b0, ent: '0};
  assign scan[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pht_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (link[i]),
      .right_o      (link[i+1]),
      .scan_right_i (scan[i+1]),
      .scan_o       (scan[i])
    );
    assign hits[i] = scan[i].hit;
  end

  assign full     = link[TABLE_DEPTH].valid;
  assign rest     = |hits[TABLE_DEPTH-1:1];
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    id_d        = id_q;
    last_d      = last_q;
    cmd.ins     = 1'b0;
    cmd.load    = 1'b0;
    cmd.shift   = 1'b0;
    cmd.ent     = '{prio: priority_req_i, evt: event_code_i,
                    wild: any_event_i, hid: handler_id_i};
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (op_i == OP_REGISTER) begin
            cmd.ins     = !full;
            out_valid_d = 1'b1;
            status_d    = full ? ST_FULL : ST_REGISTERED;
            id_d        = '0;
            last_d      = 1'b1;
          end else begin
            cmd.load = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (hits[0]) begin
            out_valid_d = 1'b1;
            status_d    = ST_MATCH;
            id_d        = scan[0].hid;
            last_d      = !rest;
            cmd.shift   = 1'b1;
            if (!rest) begin
              state_d = S_IDLE;
            end
          end else if (!rest) begin
            // nothing matched at all
            out_valid_d = 1'b1;
            status_d    = ST_NO_MATCH;
            id_d        = '0;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign match_id_o  = id_q;
  assign last_o      = last_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the priority handler table against a behavioral copy of the table
// ----------------------------------------------------------------------------
// Register and dispatch requests are sent through the valid/stall handshake,
// with random gaps on the sender side and random stalls on the result side.
// Every accepted request updates a local copy of the sorted table. That copy
// produces the expected results, which are matched in order against the
// results that leave the block.
// ----------------------------------------------------------------------------
module tb;
  import pht_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_e    status;
    logic [7:0] id;
    logic       last;
  } handler_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        op_i           = OP_REGISTER;
  logic [15:0] priority_req_i = '0;
  logic [7:0]  event_code_i   = '0;
  logic        any_event_i    = 1'b0;
  logic [7:0]  handler_id_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  match_id_o;
  logic        last_o;

  // local copy of the sorted handler table
  pht_entry_t      handler_table [TABLE_DEPTH];
  int unsigned     table_count = 0;
  handler_result_t pending_results [$];

  int   error_count = 0;
  logic quiet       = 1'b0;

  logic            mon_fire = 1'b0;
  logic [1:0]      mon_status;
  logic [7:0]      mon_id;
  logic            mon_last;
  handler_result_t want;

  priority_handler_table_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .event_code_i   (event_code_i),
    .any_event_i    (any_event_i),
    .handler_id_i   (handler_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .match_id_o     (match_id_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 12);
  end

  // update the table copy and queue the results of one accepted request
  function automatic void predict_request(input logic op, input logic [15:0] prio,
                                          input logic [7:0] ev, input logic wild,
                                          input logic [7:0] hid);
    int unsigned pos;
    int          hits;
    if (op == OP_REGISTER) begin
      if (table_count >= TABLE_DEPTH) begin
        pending_results.push_back('{ST_FULL, 8'd0, 1'b1});
      end else begin
        pos = table_count;
        // insert after every entry of equal or lower priority
        while (pos > 0 && $signed(handler_table[pos-1].prio) > $signed(prio)) begin
          handler_table[pos] = handler_table[pos-1];
          pos--;
        end
        handler_table[pos] = '{prio: prio, evt: ev, wild: wild, hid: hid};
        table_count++;
        pending_results.push_back('{ST_REGISTERED, 8'd0, 1'b1});
      end
    end else begin
      hits = 0;
      for (int i = 0; i < table_count; i++) begin
        if (handler_table[i].wild || handler_table[i].evt == ev) begin
          pending_results.push_back('{ST_MATCH, handler_table[i].hid, 1'b0});
          hits++;
        end
      end
      if (hits == 0) begin
        pending_results.push_back('{ST_NO_MATCH, 8'd0, 1'b1});
      end else begin
        pending_results[pending_results.size()-1].last = 1'b1;
      end
    end
  endfunction

  task automatic send_request(input logic op, input logic [15:0] prio, input logic [7:0] ev,
                              input logic wild, input logic [7:0] hid);
    logic stalled;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    priority_req_i <= prio;
    event_code_i   <= ev;
    any_event_i    <= wild;
    handler_id_i   <= hid;
    do begin
      // stall is stable by the falling edge, so the decision made here holds
      @(negedge clk_i);
      stalled = in_stall_o;
      if (!stalled) predict_request(op, prio, ev, wild, hid);
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int reg_pct);
    logic        op;
    logic [15:0] prio;
    logic [7:0]  ev;
    logic        wild;
    op = ($urandom_range(0, 99) < reg_pct) ? OP_REGISTER : OP_DISPATCH;
    case ($urandom_range(0, 3))
      0:       prio = 16'($urandom);
      3:       prio = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: prio = 16'(int'($urandom_range(0, 8)) - 4);  // many ties
    endcase
    // a narrow event range keeps dispatches hitting several entries
    ev   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    wild = (op == OP_REGISTER) ? ($urandom_range(0, 99) < 15) : 1'($urandom);
    send_request(op, prio, ev, wild, 8'($urandom));
  endtask

  task automatic test_empty_dispatch();
    send_request(OP_DISPATCH, 16'h1234, 8'd0, 1'b1, 8'hff);
    send_request(OP_DISPATCH, 16'h8000, 8'd255, 1'b1, 8'h00);
  endtask

  task automatic test_priority_extremes();
    send_request(OP_REGISTER, 16'h7fff, 8'd255, 1'b0, 8'd255);
    send_request(OP_REGISTER, 16'h8000, 8'd0, 1'b0, 8'd0);
    send_request(OP_REGISTER, 16'h0000, 8'd3, 1'b0, 8'h5a);
    send_request(OP_DISPATCH, 16'h0000, 8'd255, 1'b0, 8'h00);
    send_request(OP_DISPATCH, 16'hffff, 8'd0, 1'b1, 8'h77);
    send_request(OP_DISPATCH, 16'h7fff, 8'd3, 1'b0, 8'hff);
  endtask

  task automatic test_equal_priority();
    send_request(OP_REGISTER, 16'h0000, 8'd7, 1'b0, 8'd1);
    send_request(OP_REGISTER, 16'h0000, 8'd7, 1'b0, 8'd2);
    send_request(OP_REGISTER, 16'h0000, 8'd7, 1'b0, 8'd3);
    send_request(OP_DISPATCH, 16'h8000, 8'd7, 1'b0, 8'hc3);
  endtask

  task automatic test_wildcard();
    send_request(OP_REGISTER, 16'hfffb, 8'd200, 1'b1, 8'ha5);
    send_request(OP_DISPATCH, 16'h0000, 8'd9, 1'b0, 8'h00);
    send_request(OP_DISPATCH, 16'h0000, 8'd7, 1'b1, 8'h3c);
    send_request(OP_DISPATCH, 16'h0000, 8'd255, 1'b0, 8'h00);
  endtask

  task automatic test_random_fill();
    while (table_count < TABLE_DEPTH) send_random(50);
  endtask

  task automatic test_full_table();
    wait_drain();
    send_request(OP_REGISTER, 16'h8000, 8'd1, 1'b1, 8'hee);
    send_request(OP_REGISTER, 16'h7fff, 8'd2, 1'b0, 8'h11);
    send_request(OP_DISPATCH, 16'h0000, 8'd200, 1'b0, 8'h00);
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 300; n++) begin
      quiet = (n >= 120 && n < 200);
      send_random(15);
    end
    quiet = 1'b0;
  endtask

  // sample on the falling edge, check on the rising edge that accepts
  always @(negedge clk_i) begin
    mon_fire   = rst_ni && out_valid_o && !out_stall_i;
    mon_status = status_o;
    mon_id     = match_id_o;
    mon_last   = last_o;
  end

  always @(posedge clk_i) begin
    if (mon_fire) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d id %0d last %0d",
                 $time, mon_status, mon_id, mon_last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (mon_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, mon_status);
          error_count++;
        end
        if (mon_id !== want.id) begin
          $display("%0t: match_id mismatch, expected %0d, actual %0d",
                   $time, want.id, mon_id);
          error_count++;
        end
        if (mon_last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, mon_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_dispatch();
    test_priority_extremes();
    test_equal_priority();
    test_wildcard();
    test_random_fill();
    test_full_table();
    test_random_traffic();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
